// ===== rtl/rdh_pkg.sv =====
package rdh_pkg;

    localparam int ADDR_BITS_DEF   = 16;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int CMD_W   = 1;
    localparam int ADDR_W  = 16;
    localparam int BIN_W   = 7;
    localparam int DIST_W  = 7;
    localparam int COUNT_W = 32;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] address;
        logic [BIN_W-1:0]  bin;
    } req_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [COUNT_W-1:0] bin_count;
        logic [DIST_W-1:0]  max_distance;
    } rsp_t;

    // front to back: request plus the seen flag looked up by the front
    typedef struct packed {
        req_t req;
        logic seen;
    } job_t;

endpackage

// ===== rtl/rdh_if.sv =====
interface rdh_req_if;
    import rdh_pkg::*;
    logic valid;
    logic ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
    logic [BIN_W-1:0]  bin;
    modport source (output valid, cmd, address, bin, input ready);
    modport sink (input valid, cmd, address, bin, output ready);
endinterface

interface rdh_rsp_if;
    import rdh_pkg::*;
    logic valid;
    logic ready;
    logic [DIST_W-1:0]  distance;
    logic [COUNT_W-1:0] bin_count;
    logic [DIST_W-1:0]  max_distance;
    modport source (output valid, distance, bin_count, max_distance, input ready);
    modport sink (input valid, distance, bin_count, max_distance, output ready);
endinterface

// ===== rtl/rdh_front.sv =====
// Accepts requests, clears the seen map after reset, and does the seen-map
// read-modify-write for accesses. Emits one job per request.
module rdh_front #(
    parameter int ADDR_BITS = rdh_pkg::ADDR_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    rdh_req_if.sink        req,
    output logic           job_valid,
    input  logic           job_ready,
    output rdh_pkg::job_t  job
);
    import rdh_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;
    localparam logic [1:0] ST_SEND  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [ADDR_BITS:0]   clr_reg, clr_next;
    req_t                 req_reg;
    logic                 seen_reg;
    logic                 seen_map [2**ADDR_BITS];
    logic [ADDR_BITS-1:0] a_idx;

    assign a_idx     = ADDR_BITS'(req_reg.address);
    assign req.ready = (state_reg == ST_IDLE);
    assign job_valid = (state_reg == ST_SEND);
    assign job.req   = req_reg;
    assign job.seen  = seen_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (ADDR_BITS+1)'((2**ADDR_BITS) - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
                if (req.valid)
                    state_next = (req.cmd == CMD_ACCESS) ? ST_LOOK : ST_SEND;
            ST_LOOK:
                state_next = ST_SEND;
            ST_SEND:
                if (job_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req.valid)
        begin
            req_reg.cmd     <= req.cmd;
            req_reg.address <= req.address;
            req_reg.bin     <= req.bin;
            seen_reg        <= 1'b0;
        end
        if (state_reg == ST_LOOK)
            seen_reg <= seen_map[a_idx];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            seen_map[clr_reg[ADDR_BITS-1:0]] <= 1'b0;
        else if (state_reg == ST_LOOK)
            seen_map[a_idx] <= 1'b1;
    end

endmodule

// ===== rtl/rdh_queue.sv =====
// Two-entry job queue between front and back.
module rdh_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rdh_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output rdh_pkg::job_t out_job
);
    import rdh_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_job;
    end

endmodule

// ===== rtl/rdh_back.sv =====
// Recency stack search and move-to-front, histogram update and reads.
// The histogram is a memory, cleared one bin at a time after reset.
module rdh_back #(
    parameter int ADDR_BITS   = rdh_pkg::ADDR_BITS_DEF,
    parameter int STACK_DEPTH = rdh_pkg::STACK_DEPTH_DEF,
    parameter int COUNT_BITS  = rdh_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  rdh_pkg::job_t job,
    rdh_rsp_if.source     rsp
);
    import rdh_pkg::*;

    localparam int NUM_BINS = STACK_DEPTH + 2;
    localparam int POS_W    = $clog2(STACK_DEPTH + 1);
    localparam int HB_W     = $clog2(NUM_BINS);
    localparam logic [HB_W-1:0] OVF = HB_W'(STACK_DEPTH + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]            state_reg;
    logic [HB_W-1:0]       clr_reg;
    logic [ADDR_BITS-1:0]  stk_reg [STACK_DEPTH];
    logic [POS_W-1:0]      fill_reg;
    logic [COUNT_BITS-1:0] hist_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] hval_reg;
    logic [HB_W-1:0]       maxd_reg;
    logic [HB_W-1:0]       dist_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [POS_W-1:0]      upto_reg;

    logic [ADDR_BITS-1:0]  a;
    logic [STACK_DEPTH-1:0] hit;
    logic [POS_W-1:0]      hpos;
    logic                  found;
    logic [HB_W-1:0]       dist_c;
    logic [POS_W-1:0]      upto_c;
    logic [HB_W-1:0]       hb;
    logic [HB_W-1:0]       rb;

    assign a         = ADDR_BITS'(job.req.address);
    assign job_ready = (state_reg == ST_IDLE);
    assign rsp.valid = (state_reg == ST_OUT);
    assign rsp.distance     = DIST_W'(dist_reg);
    assign rsp.bin_count    = cnt_reg;
    assign rsp.max_distance = DIST_W'(maxd_reg);
    assign hb = dist_reg;
    assign rb = HB_W'(job.req.bin);

    always_comb
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
            hit[i] = (stk_reg[i] == a) && (POS_W'(i) < fill_reg);
    end

    always_comb
    begin
        hpos  = '0;
        found = 1'b0;
        for (int i = STACK_DEPTH - 1; i >= 0; i--)
            if (hit[i])
            begin
                hpos  = POS_W'(i);
                found = 1'b1;
            end
    end

    always_comb
    begin
        if (!job.seen)
            dist_c = '0;
        else if (found)
            dist_c = HB_W'(hpos) + 1'b1;
        else
            dist_c = OVF;
        upto_c = (job.seen && found) ? hpos : fill_reg;
        if (upto_c >= POS_W'(STACK_DEPTH))
            upto_c = POS_W'(STACK_DEPTH - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            fill_reg  <= '0;
            maxd_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == HB_W'(NUM_BINS - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                    if (job_valid)
                    begin
                        if (job.req.cmd == CMD_ACCESS)
                        begin
                            state_reg <= ST_SHIFT;
                            if ((!job.seen || !found) && fill_reg < POS_W'(STACK_DEPTH))
                                fill_reg <= fill_reg + 1'b1;
                        end
                        else
                            state_reg <= ST_OUT;
                    end
                ST_SHIFT:
                    state_reg <= ST_UPD;
                ST_UPD:
                begin
                    state_reg <= ST_OUT;
                    if (dist_reg > maxd_reg)
                        maxd_reg <= dist_reg;
                end
                ST_OUT:
                    if (rsp.ready)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            hist_mem[clr_reg] <= '0;
        else if (state_reg == ST_UPD && dist_reg != '0 && hval_reg != {COUNT_BITS{1'b1}})
            hist_mem[hb] <= hval_reg + 1'b1;
        if (state_reg == ST_SHIFT)
            hval_reg <= hist_mem[hb];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid)
        begin
            addr_reg <= a;
            upto_reg <= upto_c;
            if (job.req.cmd == CMD_ACCESS)
            begin
                dist_reg <= dist_c;
                cnt_reg  <= '0;
            end
            else
            begin
                dist_reg <= '0;
                if (32'(job.req.bin) < NUM_BINS)
                    cnt_reg <= COUNT_W'(hist_mem[rb]);
                else
                    cnt_reg <= '0;
            end
        end
        if (state_reg == ST_SHIFT)
        begin
            // shift entries above the hit position down, new address on top
            for (int i = 1; i < STACK_DEPTH; i++)
                if (POS_W'(i) <= upto_reg)
                    stk_reg[i] <= stk_reg[i-1];
            stk_reg[0] <= addr_reg;
        end
    end

endmodule

// ===== rtl/reuse_distance_histogram.sv =====
// Channel | Dir | Fields
// req     | in  | cmd, address, bin
// rsp     | out | distance, bin_count, max_distance
//
// An access goes through the front as take, seen-map read-modify-write and hand-off,
// and through the back as stack search, shift and bin read, bin write and response;
// the back takes no new job until its response is taken.
// A bin read goes through take and hand-off in the front, bin read and response in the back.
// After reset the seen map is cleared with req.ready low, and the histogram's
// STACK_DEPTH+2 bins are cleared alongside.
// A stalled response holds the back; the front keeps working until the queue fills.
module reuse_distance_histogram #(
    parameter int ADDR_BITS   = rdh_pkg::ADDR_BITS_DEF,
    parameter int STACK_DEPTH = rdh_pkg::STACK_DEPTH_DEF,
    parameter int COUNT_BITS  = rdh_pkg::COUNT_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    rdh_req_if.sink   req,
    rdh_rsp_if.source rsp
);
    import rdh_pkg::*;

    logic f_valid, f_ready, b_valid, b_ready;
    job_t f_job, b_job;

    rdh_front #(.ADDR_BITS(ADDR_BITS)) u_front (
        .clk, .rst_n, .req,
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    rdh_queue u_queue (
        .clk, .rst_n,
        .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
        .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
    );

    rdh_back #(
        .ADDR_BITS(ADDR_BITS), .STACK_DEPTH(STACK_DEPTH), .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .clk, .rst_n,
        .job_valid(b_valid), .job_ready(b_ready), .job(b_job), .rsp
    );

endmodule
